// File: design/swm_pkg.sv
// Shared constants and types for the sliding window median filter.
`default_nettype none

package swm_pkg;

	localparam int WIN_LEN = 7;
	localparam int SMP_W   = 24;
	localparam int AGE_W   = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
	localparam int MED_IDX = WIN_LEN / 2;

	localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(WIN_LEN - 1);

	typedef logic [SMP_W-1:0] smp_t;
	typedef logic [AGE_W-1:0] age_t;

	// What a cell shows its neighbours: stored entry plus its compare result
	typedef struct packed {
		smp_t val;
		age_t age;
		logic vld;
		logic le;   // valid and value <= incoming sample
	} cell_link_t;

endpackage

`default_nettype wire

// File: design/swm_if.sv
// Stream interfaces for the sample input and the filtered output.
`default_nettype none

interface swm_in_if;
	logic               valid;
	logic               ready;
	swm_pkg::smp_t      sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface swm_out_if;
	logic               valid;
	logic               ready;
	swm_pkg::smp_t      filtered;
	logic               window_full;

	modport source (output valid, output filtered, output window_full, input ready);
	modport sink   (input valid, input filtered, input window_full, output ready);
endinterface

`default_nettype wire

// File: design/sliding_window_median_filter.sv
// Top level of the sliding window median filter: sorted cell chain and output register.
//
// Usage notes
//  - samples: one 24-bit pressure item (0.01 Pa per step) per valid/ready handshake.
//  - results: one item per accepted sample, in order: filtered and window_full.
//  - Until WIN_LEN samples have been taken since reset, filtered is the sample itself
//    and window_full is 0; from the WIN_LEN-th sample on it is the element of rank
//    WIN_LEN/2 of the last WIN_LEN samples in ascending order (upper median if even).
//  - Window is held as a row of WIN_LEN cells kept in ascending order, each with the
//    age of its entry; each accepted item inserts the new sample, evicting the oldest
//    once the window is full, each cell taking from itself, a neighbour or the sample.
//  - Latency: result is valid in the cycle after the sample is accepted.
//  - Throughput: one item per cycle while results are taken; the whole cell row updates together.
//  - Stall: the output register holds its item while results.ready is low, and
//    samples.ready drops then, so no item is lost; it rises again as soon as the
//    held item is taken (ready passes straight through from the receiver).
//  - Reset (arst_n low): cells are marked empty, the fill counter clears and any
//    pending result is dropped. No clearing pass is needed.
`default_nettype none

module sliding_window_median_filter (
	input  wire        clk,
	input  wire        arst_n,
	swm_in_if.sink     samples,
	swm_out_if.source  results
);

	localparam int N = swm_pkg::WIN_LEN;

	swm_pkg::cell_link_t lk [0:N+1];
	logic                evb [0:N];
	swm_pkg::smp_t       nxt [0:N-1];
	logic [N-1:0]        evict_vec;
	logic [N-1:0]        vld_vec;

	logic                accept;
	logic                out_valid_q;
	swm_pkg::smp_t       filtered_q;
	logic                full_q;

	swm_pkg::age_t       wp_q;      // write position within the ring
	logic                filled_q;  // ring has wrapped at least once
	logic                filled_d;

	assign samples.ready = !out_valid_q || results.ready;
	assign accept        = samples.valid && samples.ready;

	// Boundaries: left of the lowest cell everything is "below" the sample,
	// right of the highest cell nothing is there.
	assign lk[0].val   = '0;
	assign lk[0].age   = '0;
	assign lk[0].vld   = 1'b1;
	assign lk[0].le    = 1'b1;
	assign lk[N+1].val = '0;
	assign lk[N+1].age = '0;
	assign lk[N+1].vld = 1'b0;
	assign lk[N+1].le  = 1'b0;

	assign evb[0] = 1'b0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		swm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (accept),
			.sample  (samples.sample),
			.lft     (lk[i]),
			.rgt     (lk[i+2]),
			.evb_in  (evb[i]),
			.link    (lk[i+1]),
			.evb_out (evb[i+1]),
			.nxt_val (nxt[i])
		);
		assign evict_vec[i] = evb[i+1] & ~evb[i];
		assign vld_vec[i]   = lk[i+1].vld;
	end

	// Fill tracking: the window counts as full from the item that wraps the ring
	assign filled_d = filled_q || (wp_q == swm_pkg::AGE_OLDEST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			filled_q <= 1'b0;
		end else if (accept) begin
			if (wp_q == swm_pkg::AGE_OLDEST) begin
				wp_q <= '0;
			end else begin
				wp_q <= wp_q + 1'b1;
			end
			filled_q <= filled_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			filtered_q <= filled_d ? nxt[swm_pkg::MED_IDX] : samples.sample;
			full_q     <= filled_d;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.filtered    = filtered_q;
	assign results.window_full = full_q;

`ifndef SYNTHESIS
	// Never more than one entry leaves the window per item
	a_one_evict: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(evict_vec))
		else $error("more than one cell evicting");

	// Once full, every item evicts exactly one entry
	a_full_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && filled_q) |-> $onehot(evict_vec))
		else $error("full window without a single eviction");

	// Full window means every cell holds an entry
	a_full_cells: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q |-> (&vld_vec))
		else $error("window full but a cell is empty");

	// A held result blocks new items
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !results.ready) |-> !accept)
		else $error("item taken while result stalled");
`endif

endmodule

`default_nettype wire

// File: design/swm_cell.sv
// One cell of the sorted window: holds an entry and its age, shifts with neighbours.
`default_nettype none

module swm_cell (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       en,
	input  wire swm_pkg::smp_t        sample,
	input  wire swm_pkg::cell_link_t  lft,
	input  wire swm_pkg::cell_link_t  rgt,
	input  wire                       evb_in,
	output swm_pkg::cell_link_t       link,
	output logic                      evb_out,
	output swm_pkg::smp_t             nxt_val
);

	swm_pkg::smp_t val_q;
	swm_pkg::age_t age_q;
	logic          vld_q;

	logic          evict;
	logic          le;
	swm_pkg::smp_t val_d;
	swm_pkg::age_t age_d;

	assign evict   = vld_q && (age_q == swm_pkg::AGE_OLDEST);
	assign le      = vld_q && (val_q <= sample);
	assign evb_out = evb_in | evict;

	assign link.val = val_q;
	assign link.age = age_q;
	assign link.vld = vld_q;
	assign link.le  = le;

	// Below the evicted entry: stay, take the sample, or shift up from the left.
	// At the evicted entry: pull down from the right, take the sample, or shift up.
	// Above it: pull down from the right, take the sample, or stay.
	always_comb begin
		val_d = val_q;
		age_d = age_q + 1'b1;
		if (!evb_in && !evict) begin
			if (le) begin
				val_d = val_q;
				age_d = age_q + 1'b1;
			end else if (lft.le) begin
				val_d = sample;
				age_d = '0;
			end else begin
				val_d = lft.val;
				age_d = lft.age + 1'b1;
			end
		end else if (!evb_in) begin
			if (rgt.le) begin
				val_d = rgt.val;
				age_d = rgt.age + 1'b1;
			end else if (lft.le) begin
				val_d = sample;
				age_d = '0;
			end else begin
				val_d = lft.val;
				age_d = lft.age + 1'b1;
			end
		end else begin
			if (rgt.le) begin
				val_d = rgt.val;
				age_d = rgt.age + 1'b1;
			end else if (le) begin
				val_d = sample;
				age_d = '0;
			end else begin
				val_d = val_q;
				age_d = age_q + 1'b1;
			end
		end
	end

	assign nxt_val = val_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_q | lft.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_q <= val_d;
			age_q <= age_d;
		end
	end

endmodule

`default_nettype wire

// File: bench/tb_sliding_window_median_filter.sv
// Self-checking bench for the sliding window median filter against a window model.
module tb_sliding_window_median_filter;
	timeunit 1ns;
	timeprecision 1ps;

	// Sizing of the run
	localparam int     N_RANDOM      = 1130;
	localparam int     CALM_TAIL     = 150;     // last items sent with no idling on either side
	localparam int     SETTLE_CYCLES = 8;       // settling time after the last result, with plenty of margin
	localparam longint CYCLE_LIMIT   = 200000;  // watchdog bound for the whole run
	localparam swm_pkg::smp_t SEA_LEVEL = 24'd10132500;
	localparam swm_pkg::smp_t SMP_MAX   = '1;

	// One pending input item; drain_first holds it back until the output side is empty
	typedef struct {
		swm_pkg::smp_t value;
		bit            drain_first;
	} pend_item_t;

	// One filtered result as the block should deliver it
	typedef struct packed {
		swm_pkg::smp_t filtered;
		logic          window_full;
	} filt_res_t;

	logic clk;
	logic arst_n;

	swm_in_if  samples_bus ();
	swm_out_if results_bus ();

	sliding_window_median_filter u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_bus),
		.results (results_bus)
	);

	pend_item_t pending[$];      // items still to be offered
	filt_res_t  median_due[$];   // results owed by the block, oldest first

	// Window model: ring of the last WIN_LEN samples plus fill state
	swm_pkg::smp_t win_hist[swm_pkg::WIN_LEN];
	int            win_wr_idx  = 0;
	bit            win_wrapped = 1'b0;

	int            err_cnt = 0;
	longint        cyc_cnt = 0;
	int            src_gap = 0;
	int            snk_gap = 0;
	swm_pkg::smp_t last_val = '0;

	// ------------------------------------------------------------------
	// Window model. Writes the sample into the ring, then gives either the
	// sample itself (ring not yet wrapped) or the element of rank WIN_LEN/2
	// of the ring in ascending order. Ties sort by value only, so the
	// arrangement of equal entries cannot matter.
	// ------------------------------------------------------------------
	function automatic filt_res_t next_result(swm_pkg::smp_t s);
		swm_pkg::smp_t ord[swm_pkg::WIN_LEN];
		swm_pkg::smp_t v;
		int            j;
		filt_res_t     r;
		win_hist[win_wr_idx] = s;
		win_wr_idx++;
		if (win_wr_idx == swm_pkg::WIN_LEN) begin
			win_wr_idx  = 0;
			win_wrapped = 1'b1;
		end
		if (!win_wrapped) begin
			r.filtered    = s;
			r.window_full = 1'b0;
			return r;
		end
		ord = win_hist;
		for (int i = 1; i < swm_pkg::WIN_LEN; i++) begin
			v = ord[i];
			j = i;
			while (j > 0 && ord[j-1] > v) begin
				ord[j] = ord[j-1];
				j--;
			end
			ord[j] = v;
		end
		r.filtered    = ord[swm_pkg::MED_IDX];
		r.window_full = 1'b1;
		return r;
	endfunction

	// Idling only outside the calm tail, and with regular stretches of none at all
	function automatic bit idle_ok();
		return pending.size() > CALM_TAIL && (cyc_cnt / 400) % 4 != 3;
	endfunction

	task automatic report_mismatch(string what, swm_pkg::smp_t got, swm_pkg::smp_t want);
		$display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
		err_cnt++;
	endtask

	task automatic add_item(swm_pkg::smp_t v, bit drain);
		pend_item_t p;
		p.value       = v;
		p.drain_first = drain;
		pending.push_back(p);
		last_val = v;
	endtask

	// Random sample: mostly full range or around sea level, with extremes,
	// repeats (ties in the window) and single set or cleared bits mixed in
	function automatic swm_pkg::smp_t rand_sample();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return swm_pkg::smp_t'($urandom);
			4, 5, 6:    return SEA_LEVEL + swm_pkg::smp_t'($urandom_range(0, 2000))
						- swm_pkg::smp_t'(1000);
			7: begin
				case ($urandom_range(0, 3))
					0:       return '0;
					1:       return SMP_MAX;
					2:       return swm_pkg::smp_t'(1);
					default: return SMP_MAX - swm_pkg::smp_t'(1);
				endcase
			end
			8:       return last_val;
			default: begin
				if ($urandom_range(0, 1))
					return swm_pkg::smp_t'(1) << $urandom_range(0, swm_pkg::SMP_W - 1);
				return ~(swm_pkg::smp_t'(1) << $urandom_range(0, swm_pkg::SMP_W - 1));
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Cycle counter doubles as the watchdog
	always @(posedge clk) begin
		cyc_cnt++;
		if (cyc_cnt == CYCLE_LIMIT) begin
			$display("tb_sliding_window_median_filter: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Driver: offers pending items on the sample side. valid is only
	// changed when the current item has been taken or none is on offer.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (samples_bus.valid && samples_bus.ready)
				median_due.push_back(next_result(samples_bus.sample));
			if (!samples_bus.valid || samples_bus.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					samples_bus.valid <= 1'b0;
				end else if (pending.size() == 0 ||
						(pending[0].drain_first && median_due.size() != 0)) begin
					// nothing left, or holding off until every result is back
					samples_bus.valid <= 1'b0;
				end else if (idle_ok() && $urandom_range(0, 5) == 0) begin
					src_gap = $urandom_range(1, 17) - 1;
					samples_bus.valid <= 1'b0;
				end else begin
					samples_bus.valid  <= 1'b1;
					samples_bus.sample <= pending[0].value;
					void'(pending.pop_front());
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each taken result against the oldest one owed, and
	// stalls the result side in random bursts.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_side
		filt_res_t want;
		if (arst_n) begin
			if (results_bus.valid && results_bus.ready) begin
				if (median_due.size() == 0) begin
					report_mismatch("unexpected result", results_bus.filtered, '0);
				end else begin
					want = median_due.pop_front();
					if (results_bus.filtered !== want.filtered)
						report_mismatch("filtered", results_bus.filtered, want.filtered);
					if (results_bus.window_full !== want.window_full)
						report_mismatch("window_full",
							swm_pkg::smp_t'(results_bus.window_full),
							swm_pkg::smp_t'(want.window_full));
				end
			end
			if (snk_gap > 0) begin
				snk_gap--;
				results_bus.ready <= 1'b0;
			end else if (idle_ok() && $urandom_range(0, 5) == 0) begin
				snk_gap = $urandom_range(1, 17) - 1;
				results_bus.ready <= 1'b0;
			end else begin
				results_bus.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus, reset and end of run
	// ------------------------------------------------------------------
	initial begin
		arst_n             = 1'b0;
		samples_bus.valid  = 1'b0;
		samples_bus.sample = '0;
		results_bus.ready  = 1'b0;

		// Field extremes and mid-scale edges; the seventh item completes the
		// first wrap, so the first median comes from these
		add_item('0, 1'b0);
		add_item(SMP_MAX, 1'b0);
		add_item(SMP_MAX, 1'b0);
		add_item('0, 1'b0);
		add_item(swm_pkg::smp_t'(1), 1'b0);
		add_item(24'h800000, 1'b0);
		add_item(24'h7FFFFF, 1'b0);
		// A whole window of equal samples: ties
		for (int i = 0; i < swm_pkg::WIN_LEN; i++)
			add_item(SEA_LEVEL, 1'b0);
		// Rising run near the top of the range, then a falling run
		for (int i = 0; i < 6; i++)
			add_item(SMP_MAX - swm_pkg::smp_t'(5 - i), 1'b0);
		for (int i = 0; i < 5; i++)
			add_item(swm_pkg::smp_t'(4 - i), 1'b0);

		// Random part; every 300 items the sender waits for the output to empty
		for (int k = 0; k < N_RANDOM; k++)
			add_item(rand_sample(), (k % 300) == 0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || samples_bus.valid || median_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (err_cnt == 0 && median_due.size() == 0)
			$display("tb_sliding_window_median_filter: PASS");
		else
			$display("tb_sliding_window_median_filter: FAIL");
		$finish;
	end

endmodule

// File: sim.f
design/swm_pkg.sv
design/swm_if.sv
design/swm_cell.sv
design/sliding_window_median_filter.sv
bench/tb_sliding_window_median_filter.sv
